### design/ptlm_pkg.sv
`default_nettype none

package ptlm_pkg;

  localparam int unsigned ADDR_IN_W = 32;
  localparam int unsigned PLEN_W    = 6;
  localparam int unsigned KEY_W     = 7;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_LOOKUP = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_FULL = 2'd2,
    STAT_MISS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic [1:0]           action;
    logic [ADDR_IN_W-1:0] address;
    logic [PLEN_W-1:0]    prefix_len;
    logic [KEY_W-1:0]     entry_key;
  } in_beat_t;

  typedef struct packed {
    logic             found;
    logic [KEY_W-1:0] match_key;
    status_t          status;
  } out_beat_t;

endpackage

`default_nettype wire

### design/ptlm_cell.sv
`default_nettype none

module ptlm_cell import ptlm_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned ADDRESS_BITS  = 32,
  parameter int unsigned CELL_IDX      = 0,
  localparam int unsigned AB = ADDRESS_BITS,
  localparam int unsigned LW = $clog2(ADDRESS_BITS + 1),
  localparam int unsigned IW = $clog2(TABLE_ENTRIES)
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic tok_in_vld,
  input  wire logic [AB+2*LW+KEY_W+2*IW+3-1:0] tok_in,
  output logic      tok_out_vld,
  output logic [AB+2*LW+KEY_W+2*IW+3-1:0] tok_out,
  input  wire logic [AB*2+LW+KEY_W+IW+2-1:0] wr_in
);

  // search token walking the chain
  typedef struct packed {
    logic [AB-1:0]    addr;
    logic [LW-1:0]    len;
    logic             found;
    logic [LW-1:0]    best_len;
    logic [KEY_W-1:0] best_key;
    logic             hit;
    logic [IW-1:0]    hit_idx;
    logic             free_ok;
    logic [IW-1:0]    free_idx;
  } tok_t;

  // entry update, broadcast to every cell
  typedef struct packed {
    logic             en;
    logic             del;
    logic [IW-1:0]    idx;
    logic [AB-1:0]    base;
    logic [AB-1:0]    mask;
    logic [LW-1:0]    len;
    logic [KEY_W-1:0] key;
  } wr_t;

  tok_t             tin;
  tok_t             tok_nxt;
  tok_t             tok_r;
  logic             tok_vld_r;
  wr_t              wr;
  logic             ent_vld_r;
  logic [AB-1:0]    ent_base_r;
  logic [AB-1:0]    ent_mask_r;
  logic [LW-1:0]    ent_len_r;
  logic [KEY_W-1:0] ent_key_r;
  logic             same;
  logic             cont;
  logic             sel;

  assign tin = tok_t'(tok_in);
  assign wr  = wr_t'(wr_in);
  assign sel = wr.en && (wr.idx == IW'(CELL_IDX));

  assign same = ent_vld_r && (ent_base_r == tin.addr) && (ent_len_r == tin.len);
  assign cont = ent_vld_r && ((tin.addr & ent_mask_r) == ent_base_r);

  always_comb begin
    tok_nxt = tin;
    if (same) begin
      tok_nxt.hit     = 1'b1;
      tok_nxt.hit_idx = IW'(CELL_IDX);
    end
    // lowest-numbered free entry wins
    if (!tin.free_ok && !ent_vld_r) begin
      tok_nxt.free_ok  = 1'b1;
      tok_nxt.free_idx = IW'(CELL_IDX);
    end
    // longer prefix means smaller range
    if (cont && (!tin.found || (ent_len_r > tin.best_len))) begin
      tok_nxt.found    = 1'b1;
      tok_nxt.best_len = ent_len_r;
      tok_nxt.best_key = ent_key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_in_vld;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
    end else if (sel) begin
      ent_vld_r <= !wr.del;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && !wr.del) begin
      ent_base_r <= wr.base;
      ent_mask_r <= wr.mask;
      ent_len_r  <= wr.len;
      ent_key_r  <= wr.key;
    end
  end

  assign tok_out_vld = tok_vld_r;
  assign tok_out     = tok_r;

endmodule

`default_nettype wire

### design/prefix_table_longest_match_core.sv
// prefix table with longest-match lookup
// input channel: in_valid / in_stall / in_beat; a beat is taken when in_valid is
// high and in_stall low. in_beat.action selects insert (0), delete (1) or
// lookup (2); action 3 only returns an all-zero result
// result channel: out_valid / out_stall / out_beat; every input beat yields
// exactly one result beat, in order
// each table entry lives in one cell of a chain of TABLE_ENTRIES cells; a
// search token enters the first cell and moves one cell per cycle, picking up
// the duplicate match, the first free entry and the longest containing prefix
// a result passes the injection register, the register of each cell in the
// chain and the walk-end register before the result register shows it on
// out_valid; the next input beat can be taken in that same cycle, so a new
// beat waits for the last token walk and the commit that writes the chosen cell
// while the result register is still held by out_stall a finished walk waits in
// the commit step and in_stall stays high; a result register that holds a beat
// does not block acceptance of the next input beat
// reset (synchronous, rst_n low) empties the table at once; no clearing pass
`default_nettype none

module prefix_table_longest_match_core import ptlm_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned ADDRESS_BITS  = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_beat_t  in_beat,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_beat
);

  localparam int unsigned AB    = ADDRESS_BITS;
  localparam int unsigned LW    = $clog2(ADDRESS_BITS + 1);
  localparam int unsigned IW    = $clog2(TABLE_ENTRIES);
  localparam int unsigned TOK_W = AB + 2*LW + KEY_W + 2*IW + 3;
  localparam int unsigned WR_W  = AB*2 + LW + KEY_W + IW + 2;
  localparam logic [AB-1:0] ONES = {AB{1'b1}};

  typedef struct packed {
    logic [AB-1:0]    addr;
    logic [LW-1:0]    len;
    logic             found;
    logic [LW-1:0]    best_len;
    logic [KEY_W-1:0] best_key;
    logic             hit;
    logic [IW-1:0]    hit_idx;
    logic             free_ok;
    logic [IW-1:0]    free_idx;
  } tok_t;

  typedef struct packed {
    logic             en;
    logic             del;
    logic [IW-1:0]    idx;
    logic [AB-1:0]    base;
    logic [AB-1:0]    mask;
    logic [LW-1:0]    len;
    logic [KEY_W-1:0] key;
  } wr_t;

  state_t           state_r, state_nxt;
  logic             inj_vld_r, inj_vld_nxt;
  tok_t             inj_tok_r, inj_tok_nxt;
  tok_t             end_tok_r, end_tok_nxt;
  logic [1:0]       act_r, act_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_beat_r, out_beat_nxt;
  wr_t              wr;
  out_beat_t        res;
  logic [AB-1:0]    addr_c;
  logic [AB-1:0]    mask_c;
  logic [LW-1:0]    len_c;
  logic             accept;
  logic             commit_go;

  logic [TABLE_ENTRIES:0] chain_vld;
  logic [TOK_W-1:0]       chain_tok [TABLE_ENTRIES+1];

  assign chain_vld[0] = inj_vld_r;
  assign chain_tok[0] = TOK_W'(inj_tok_r);

  for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
    ptlm_cell #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ADDRESS_BITS  (ADDRESS_BITS),
      .CELL_IDX      (gi)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .tok_in_vld  (chain_vld[gi]),
      .tok_in      (chain_tok[gi]),
      .tok_out_vld (chain_vld[gi+1]),
      .tok_out     (chain_tok[gi+1]),
      .wr_in       (WR_W'(wr))
    );
  end

  // prefix length clamp, base mask
  always_comb begin
    addr_c = AB'(in_beat.address);
    if (int'(in_beat.prefix_len) > int'(ADDRESS_BITS)) begin
      len_c = LW'(ADDRESS_BITS);
    end else begin
      len_c = LW'(in_beat.prefix_len);
    end
    mask_c = ~(ONES >> len_c);
  end

  // outcome of a finished walk
  always_comb begin
    res.found     = 1'b0;
    res.match_key = '0;
    res.status    = STAT_DONE;
    wr.en   = 1'b0;
    wr.del  = 1'b0;
    wr.idx  = end_tok_r.free_idx;
    wr.base = end_tok_r.addr;
    wr.mask = ~(ONES >> end_tok_r.len);
    wr.len  = end_tok_r.len;
    wr.key  = key_r;
    case (act_t'(act_r))
      ACT_INSERT: begin
        if (end_tok_r.hit) begin
          res.status = STAT_DUP;
        end else if (!end_tok_r.free_ok) begin
          res.status = STAT_FULL;
        end else begin
          wr.en = commit_go;
        end
      end
      ACT_DELETE: begin
        if (!end_tok_r.hit) begin
          res.status = STAT_MISS;
        end else begin
          wr.en  = commit_go;
          wr.del = 1'b1;
          wr.idx = end_tok_r.hit_idx;
        end
      end
      ACT_LOOKUP: begin
        res.found = end_tok_r.found;
        if (end_tok_r.found) begin
          res.match_key = end_tok_r.best_key;
        end
      end
      default: begin
      end
    endcase
  end

  assign accept    = in_valid && (state_r == S_IDLE);
  assign commit_go = (state_r == S_COMMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    inj_vld_nxt   = 1'b0;
    inj_tok_nxt   = inj_tok_r;
    end_tok_nxt   = end_tok_r;
    act_nxt       = act_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_beat_nxt  = out_beat_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          inj_vld_nxt          = 1'b1;
          inj_tok_nxt          = '0;
          act_nxt              = in_beat.action;
          key_nxt              = in_beat.entry_key;
          if (act_t'(in_beat.action) == ACT_LOOKUP) begin
            inj_tok_nxt.addr = addr_c;
          end else begin
            inj_tok_nxt.addr = addr_c & mask_c;
            inj_tok_nxt.len  = len_c;
          end
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (chain_vld[TABLE_ENTRIES]) begin
          end_tok_nxt = tok_t'(chain_tok[TABLE_ENTRIES]);
          state_nxt   = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit_go) begin
          out_valid_nxt = 1'b1;
          out_beat_nxt  = res;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      inj_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inj_vld_r   <= inj_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inj_tok_r  <= inj_tok_nxt;
    end_tok_r  <= end_tok_nxt;
    act_r      <= act_nxt;
    key_r      <= key_nxt;
    out_beat_r <= out_beat_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

`default_nettype wire
